// ===== design/owo_pkg.sv =====
`default_nettype none
package owo_pkg;

   localparam int NUM_WHEELS_DEF  = 4;
   localparam int COEF_COUNT      = 8;
   localparam int COEF_W          = 24;
   localparam int CSR_INDEX_W     = 4;
   localparam int CORDIC_STEPS    = 24;
   localparam int STEP_W          = 5;
   localparam int CORDIC_W        = 34;
   localparam int QUEUE_DEPTH     = 2;

   typedef struct packed {
      logic signed [15:0] wheel_speed_0;
      logic signed [15:0] wheel_speed_1;
      logic signed [15:0] wheel_speed_2;
      logic signed [15:0] wheel_speed_3;
      logic        [15:0] elapsed_time;
      logic signed [15:0] heading;
   } req_type;

   typedef struct packed {
      logic signed [31:0] position_x;
      logic signed [31:0] position_y;
      logic signed [31:0] velocity_x;
      logic signed [31:0] velocity_y;
   } rsp_type;

   // Queue entry: the item plus what the front found out about it.
   typedef struct packed {
      req_type item;
      logic    time_zero;
   } job_type;

   typedef struct packed {
      logic valid;
   } queue_ctl_type;

   function automatic logic signed [CORDIC_W-1:0] atan_angle(input logic [STEP_W-1:0] i);
      logic signed [CORDIC_W-1:0] a;
      case (i)
         5'd0:    a = 34'sd536870912;
         5'd1:    a = 34'sd316933406;
         5'd2:    a = 34'sd167458907;
         5'd3:    a = 34'sd85004756;
         5'd4:    a = 34'sd42667331;
         5'd5:    a = 34'sd21354465;
         5'd6:    a = 34'sd10679838;
         5'd7:    a = 34'sd5340245;
         5'd8:    a = 34'sd2670163;
         5'd9:    a = 34'sd1335087;
         5'd10:   a = 34'sd667544;
         5'd11:   a = 34'sd333772;
         5'd12:   a = 34'sd166886;
         5'd13:   a = 34'sd83443;
         5'd14:   a = 34'sd41722;
         5'd15:   a = 34'sd20861;
         5'd16:   a = 34'sd10430;
         5'd17:   a = 34'sd5215;
         5'd18:   a = 34'sd2608;
         5'd19:   a = 34'sd1304;
         5'd20:   a = 34'sd652;
         5'd21:   a = 34'sd326;
         5'd22:   a = 34'sd163;
         5'd23:   a = 34'sd81;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

// ===== design/omni_wheel_odometry_step_core.sv =====
`default_nettype none
// Dead-reckoning odometry for an omni-wheel base. Each request beat carries
// the wheel speeds (Q8.8 rad/s), the elapsed time (2^-16 s) and the heading
// (binary angle), and produces exactly one response beat with the saturated
// world position and the held world velocity, both Q16.16. Software loads the
// eight Q4.20 wheel coefficients through the csr_ port while the block is
// idle; an index of eight or more is ignored. A two-beat queue sits between
// the request side and the compute engine, and the response sits in its own
// register, so a new request is taken while a result waits. The engine works
// on one item at a time, from taking it off the queue to being ready for the
// next one: it takes the item, the 24-step CORDIC loads and iterates (the
// wheel multiply-accumulate of 2*NUM_WHEELS products finishes inside that
// window), it hands over, forms the four rotation products on the single
// shared 32x32 multiplier, rounds, forms the two time products, updates the
// position and loads the response. A stalled response holds the engine in
// its last step until the response register frees.
module omni_wheel_odometry_step_core #(
   parameter int NUM_WHEELS = owo_pkg::NUM_WHEELS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire owo_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output owo_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [owo_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [owo_pkg::COEF_W-1:0]      csr_wdata
);
   import owo_pkg::*;

   logic signed [COEF_W-1:0] coef_ff [COEF_COUNT];
   queue_ctl_type q_status;
   job_type       q_head;
   logic          q_pop;
   logic          cordic_start, cordic_busy;
   logic signed [15:0] cordic_heading;
   logic signed [31:0] cos_v, sin_v;

   // Coefficient registers; writes beyond the last index fall away.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < COEF_COUNT; i++) coef_ff[i] <= '0;
      end else if (csr_we && csr_index < CSR_INDEX_W'(COEF_COUNT)) begin
         coef_ff[csr_index[2:0]] <= csr_wdata;
      end
   end

   owo_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .q_status(q_status), .q_pop(q_pop), .q_head(q_head)
   );

   owo_cordic u_cordic (
      .clock(clock), .reset(reset),
      .start(cordic_start), .heading(cordic_heading), .busy(cordic_busy),
      .cos_out(cos_v), .sin_out(sin_v)
   );

   owo_back #(.NUM_WHEELS(NUM_WHEELS)) u_back (
      .clock(clock), .reset(reset), .coef(coef_ff),
      .q_status(q_status), .q_head(q_head), .q_pop(q_pop),
      .cordic_start(cordic_start), .cordic_heading(cordic_heading),
      .cordic_busy(cordic_busy), .cos_in(cos_v), .sin_in(sin_v),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );
endmodule
`default_nettype wire

// ===== design/owo_front.sv =====
`default_nettype none
module owo_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire owo_pkg::req_type req_data,
   output owo_pkg::queue_ctl_type q_status,
   input  wire logic             q_pop,
   output owo_pkg::job_type      q_head
);
   import owo_pkg::*;

   job_type mem_ff [QUEUE_DEPTH];
   logic    wr_ptr_ff, wr_ptr_in;
   logic    rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic    push;

   assign req_ready = (count_ff != 2'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_status.valid = (count_ff != 2'd0);
   assign q_head = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff].item      <= req_data;
         mem_ff[wr_ptr_ff].time_zero <= (req_data.elapsed_time == 16'd0);
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end
endmodule
`default_nettype wire

// ===== design/owo_cordic.sv =====
`default_nettype none
module owo_cordic (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [15:0] heading,
   output logic                    busy,
   output logic signed [31:0]      cos_out,
   output logic signed [31:0]      sin_out
);
   import owo_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff, y_ff, z_ff, z0;
   logic signed [CORDIC_W-1:0] dx, dy, ang, ncos, nsin;
   logic [STEP_W-1:0] step_ff;
   logic busy_ff, flip_ff, flip0;

   always_comb begin
      z0    = {{(CORDIC_W-32){heading[15]}}, heading, 16'd0};
      flip0 = 1'b0;
      if (heading > 16'sd16384) begin
         z0    = z0 - (CORDIC_W'(1) <<< 31);
         flip0 = 1'b1;
      end else if (heading < -16'sd16384) begin
         z0    = z0 + (CORDIC_W'(1) <<< 31);
         flip0 = 1'b1;
      end
      dx   = y_ff >>> step_ff;
      dy   = x_ff >>> step_ff;
      ang  = atan_angle(step_ff);
      ncos = flip_ff ? -x_ff : x_ff;
      nsin = flip_ff ? -y_ff : y_ff;
   end

   assign busy    = busy_ff;
   assign cos_out = ncos[31:0];
   assign sin_out = nsin[31:0];

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= CORDIC_W'(652032874);
         y_ff    <= '0;
         z_ff    <= z0;
         flip_ff <= flip0;
         step_ff <= '0;
      end else if (busy_ff) begin
         if (!z_ff[CORDIC_W-1]) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - ang;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + ang;
         end
         step_ff <= step_ff + 1'b1;
      end
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
         busy_ff <= 1'b0;
      end
   end
endmodule
`default_nettype wire

// ===== design/owo_back.sv =====
`default_nettype none
module owo_back #(
   parameter int NUM_WHEELS = owo_pkg::NUM_WHEELS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic signed [23:0]  coef [owo_pkg::COEF_COUNT],
   input  wire owo_pkg::queue_ctl_type q_status,
   input  wire owo_pkg::job_type    q_head,
   output logic                     q_pop,
   output logic                     cordic_start,
   output logic signed [15:0]       cordic_heading,
   input  wire logic                cordic_busy,
   input  wire logic signed [31:0]  cos_in,
   input  wire logic signed [31:0]  sin_in,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output owo_pkg::rsp_type         rsp_data
);
   import owo_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_MAC, S_WAIT, S_ROT, S_RND, S_STEP, S_UPD, S_EMIT
   } state_type;

   localparam logic [3:0] MAC_OPS = 4'(2 * NUM_WHEELS);

   state_type state_ff;
   job_type   job_ff;
   logic [3:0] cnt_ff;
   logic signed [31:0] mul_a, mul_b, bx_ff, by_ff, vx_ff, vy_ff;
   logic signed [63:0] prod_ff;
   logic signed [65:0] acc_a_ff, acc_b_ff, addend, rnd_a, rnd_b;
   logic tag_v_ff, tag_dst_ff, tag_neg_ff, tag_clr_ff;
   logic issue, op_dst, op_neg, op_clr;
   logic signed [31:0] pos_x_ff, pos_y_ff, velh_x_ff, velh_y_ff;
   logic signed [34:0] sum_x, sum_y;
   logic signed [31:0] px_in, py_in;
   logic out_v_ff;
   rsp_type out_ff;
   logic signed [15:0] speed [4];

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      if (v > 35'sd2147483647) return 32'sh7fffffff;
      if (v < -35'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   assign speed[0] = job_ff.item.wheel_speed_0;
   assign speed[1] = job_ff.item.wheel_speed_1;
   assign speed[2] = job_ff.item.wheel_speed_2;
   assign speed[3] = job_ff.item.wheel_speed_3;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      issue  = 1'b0;
      op_dst = 1'b0;
      op_neg = 1'b0;
      op_clr = 1'b0;
      case (state_ff)
         S_MAC: begin
            issue  = (cnt_ff < MAC_OPS);
            op_dst = cnt_ff[0];
            mul_a  = 32'(coef[{cnt_ff[0], cnt_ff[2:1]}]);
            mul_b  = 32'(speed[cnt_ff[2:1]]);
         end
         S_ROT: begin
            issue  = (cnt_ff < 4'd4);
            op_dst = cnt_ff[1];
            op_clr = !cnt_ff[0];
            op_neg = (cnt_ff[1:0] == 2'd1);
            mul_a  = (cnt_ff[1:0] == 2'd0 || cnt_ff[1:0] == 2'd3) ? cos_in : sin_in;
            mul_b  = (cnt_ff[1:0] == 2'd0 || cnt_ff[1:0] == 2'd2) ? bx_ff : by_ff;
         end
         S_STEP: begin
            issue  = (cnt_ff < 4'd2);
            op_dst = cnt_ff[0];
            op_clr = 1'b1;
            mul_a  = cnt_ff[0] ? vy_ff : vx_ff;
            mul_b  = {16'd0, job_ff.item.elapsed_time};
         end
         default: begin
         end
      endcase
      addend = tag_neg_ff ? -66'(prod_ff) : 66'(prod_ff);
      rnd_a  = acc_a_ff;
      rnd_b  = acc_b_ff;
      sum_x  = 35'(pos_x_ff) + 35'((acc_a_ff + 66'sd32768) >>> 16);
      sum_y  = 35'(pos_y_ff) + 35'((acc_b_ff + 66'sd32768) >>> 16);
      px_in  = sat32(sum_x);
      py_in  = sat32(sum_y);
   end

   assign q_pop          = (state_ff == S_IDLE) && q_status.valid;
   // The heading comes from the captured item, since the queue head has
   // already moved on by the time the rotation unit starts.
   assign cordic_heading = job_ff.item.heading;
   assign rsp_valid      = out_v_ff;
   assign rsp_data       = out_ff;

   always_ff @(posedge clock) begin
      prod_ff    <= mul_a * mul_b;
      tag_dst_ff <= op_dst;
      tag_neg_ff <= op_neg;
      tag_clr_ff <= op_clr;
      if (tag_v_ff) begin
         if (tag_dst_ff)
            acc_b_ff <= (tag_clr_ff ? 66'sd0 : acc_b_ff) + addend;
         else
            acc_a_ff <= (tag_clr_ff ? 66'sd0 : acc_a_ff) + addend;
      end
      if (reset) begin
         state_ff     <= S_IDLE;
         tag_v_ff     <= 1'b0;
         out_v_ff     <= 1'b0;
         cordic_start <= 1'b0;
         cnt_ff       <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         velh_x_ff    <= '0;
         velh_y_ff    <= '0;
      end else begin
         tag_v_ff     <= issue;
         cordic_start <= 1'b0;
         if (out_v_ff && rsp_ready) out_v_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (q_status.valid) begin
                  job_ff       <= q_head;
                  cordic_start <= 1'b1;
                  acc_a_ff     <= '0;
                  acc_b_ff     <= '0;
                  cnt_ff       <= '0;
                  state_ff     <= S_MAC;
               end
            end
            S_MAC: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == MAC_OPS) state_ff <= S_WAIT;
            end
            S_WAIT: begin
               bx_ff <= 32'((rnd_a + 66'sd2048) >>> 12);
               by_ff <= 32'((rnd_b + 66'sd2048) >>> 12);
               if (!cordic_busy && !cordic_start) begin
                  cnt_ff   <= '0;
                  state_ff <= S_ROT;
               end
            end
            S_ROT: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 4'd4) state_ff <= S_RND;
            end
            S_RND: begin
               vx_ff    <= 32'((rnd_a + (66'sd1 <<< 29)) >>> 30);
               vy_ff    <= 32'((rnd_b + (66'sd1 <<< 29)) >>> 30);
               cnt_ff   <= '0;
               state_ff <= S_STEP;
            end
            S_STEP: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == 4'd2) state_ff <= S_UPD;
            end
            S_UPD: begin
               pos_x_ff <= px_in;
               pos_y_ff <= py_in;
               if (!job_ff.time_zero) begin
                  velh_x_ff <= vx_ff;
                  velh_y_ff <= vy_ff;
               end
               state_ff <= S_EMIT;
            end
            S_EMIT: begin
               if (!out_v_ff || rsp_ready) begin
                  out_ff.position_x <= pos_x_ff;
                  out_ff.position_y <= pos_y_ff;
                  out_ff.velocity_x <= velh_x_ff;
                  out_ff.velocity_y <= velh_y_ff;
                  out_v_ff          <= 1'b1;
                  state_ff          <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
